// ===== sv/phfe_pkg.sv =====
// Package with layer codes, field codes and shared types of the header field extractor.
package phfe_pkg;

    typedef enum logic [2:0] {
        LAYER_ETH = 3'd0,
        LAYER_IP4 = 3'd1,
        LAYER_IP6 = 3'd2,
        LAYER_TCP = 3'd3,
        LAYER_UDP = 3'd4
    } t_layer;

    localparam logic [4:0] CODE_ETH_DST   = 5'd0;
    localparam logic [4:0] CODE_ETH_SRC   = 5'd1;
    localparam logic [4:0] CODE_ETHERTYPE = 5'd2;
    localparam logic [4:0] CODE_IP4_ID    = 5'd3;
    localparam logic [4:0] CODE_IP4_FLAGS = 5'd4;
    localparam logic [4:0] CODE_IP4_FRAG  = 5'd5;
    localparam logic [4:0] CODE_IP4_TTL   = 5'd6;
    localparam logic [4:0] CODE_IP4_SRC   = 5'd7;
    localparam logic [4:0] CODE_IP4_DST   = 5'd8;
    localparam logic [4:0] CODE_IP6_HOP   = 5'd9;
    localparam logic [4:0] CODE_IP6_SRC_H = 5'd10;
    localparam logic [4:0] CODE_IP6_SRC_L = 5'd11;
    localparam logic [4:0] CODE_IP6_DST_H = 5'd12;
    localparam logic [4:0] CODE_IP6_DST_L = 5'd13;
    localparam logic [4:0] CODE_TCP_SPORT = 5'd14;
    localparam logic [4:0] CODE_TCP_DPORT = 5'd15;
    localparam logic [4:0] CODE_TCP_SEQ   = 5'd16;
    localparam logic [4:0] CODE_TCP_ACK   = 5'd17;
    localparam logic [4:0] CODE_TCP_FLAGS = 5'd18;
    localparam logic [4:0] CODE_UDP_SPORT = 5'd19;
    localparam logic [4:0] CODE_UDP_DPORT = 5'd20;
    localparam logic [4:0] CODE_END       = 5'd21;

    localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // One classified byte: up to one field result and up to one end result.
    typedef struct packed {
        logic        fld_vld;
        logic [4:0]  fld_code;
        logic [63:0] fld_value;
        logic        end_vld;
        logic [1:0]  end_status;
    } t_work;

endpackage

// ===== sv/phfe_if.sv =====
// Valid/ready channel interfaces for input bytes and field results.
interface phfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       end_of_packet;
    modport source (output valid, output packet_byte, output end_of_packet, input ready);
    modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface phfe_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic        last;
    modport source (output valid, output field_code, output field_value, output last,
                    input ready);
    modport sink (input valid, input field_code, input field_value, input last,
                  output ready);
endinterface

// ===== sv/packet_header_field_extractor_core.sv =====
// Top level of the packet header field extractor.
// Results: a byte's results are registered in the queue when the byte is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that yields both a
// field and an end result yields two output transactions, absorbed by the queue.
// Reset: synchronous active-low i_rst_n returns the parser to the Ethernet layer and
// empties the queue; the next byte is taken as the first byte of a frame.
module packet_header_field_extractor_core #(
    parameter int QueueDepth = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    phfe_in_if.sink    i_in,
    phfe_out_if.source o_out
);

    phfe_pkg::t_work front_work, queue_work;
    logic front_vld;
    logic q_full, q_empty, q_pop;
    logic accept;

    // Input is taken whenever the queue has room, so the front end never waits on
    // the output side unless the queue fills.
    assign i_in.ready = !q_full;
    assign accept = i_in.valid && !q_full;

    phfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (accept),
        .i_byte     (i_in.packet_byte),
        .i_eop      (i_in.end_of_packet),
        .o_work     (front_work),
        .o_work_vld (front_vld)
    );

    // Only bytes that produce at least one result transaction occupy a queue slot.
    phfe_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_work  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_work  (queue_work),
        .o_empty (q_empty)
    );

    phfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_work  (queue_work),
        .o_pop   (q_pop),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_code  (o_out.field_code),
        .o_value (o_out.field_value),
        .o_last  (o_out.last)
    );

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !accept) else $error("transaction accepted into full queue");
    a_out_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !q_empty) else $error("output valid without queued data");
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.field_code <= phfe_pkg::CODE_END)
        else $error("field code out of range");

endmodule

// ===== sv/phfe_front.sv =====
// Front end: walks the header chain one byte at a time and classifies each byte.
module phfe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [7:0]           i_byte,
    input  logic                 i_eop,
    output phfe_pkg::t_work      o_work,
    output logic                 o_work_vld
);

    phfe_pkg::t_layer r_layer, n_layer;
    logic [5:0]  r_off, n_off;
    logic [5:0]  r_hlen, n_hlen;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_proto, n_proto;
    logic        r_done, n_done;
    logic [63:0] acc;
    logic [5:0]  ihl_len;
    logic [5:0]  tcp_len;
    logic        status_vld;
    logic [1:0]  status;
    phfe_pkg::t_work w;

    always_comb begin
        acc = {r_acc[55:0], i_byte};
        ihl_len = (i_byte[3:0] < 4'd5) ? 6'd20 : {i_byte[3:0], 2'b00};
        tcp_len = (i_byte[7:4] < 4'd5) ? 6'd20 : {i_byte[7:4], 2'b00};
        w = '0;
        n_layer = r_layer;
        n_off = r_off;
        n_hlen = r_hlen;
        n_acc = r_acc;
        n_proto = r_proto;
        n_done = r_done;
        status_vld = 1'b0;
        status = phfe_pkg::STATUS_COMPLETE;
        if (!r_done) begin
            n_acc = acc;
            unique case (r_layer)
                phfe_pkg::LAYER_ETH: begin
                    if (r_off == 6'd5) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_ETH_DST;
                        w.fld_value = {16'd0, acc[47:0]};
                    end else if (r_off == 6'd11) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_ETH_SRC;
                        w.fld_value = {16'd0, acc[47:0]};
                    end else if (r_off == 6'd13) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_ETHERTYPE;
                        w.fld_value = {48'd0, acc[15:0]};
                        n_proto = acc[15:0];
                    end
                end
                phfe_pkg::LAYER_IP4: begin
                    if (r_off == 6'd0) n_hlen = ihl_len;
                    if (r_off == 6'd9) n_proto = {8'd0, i_byte};
                    if (r_off == 6'd5) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_ID;
                        w.fld_value = {48'd0, acc[15:0]};
                    end else if (r_off == 6'd6) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_FLAGS;
                        w.fld_value = {61'd0, acc[7:5]};
                    end else if (r_off == 6'd7) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_FRAG;
                        w.fld_value = {51'd0, acc[12:0]};
                    end else if (r_off == 6'd8) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_TTL;
                        w.fld_value = {56'd0, acc[7:0]};
                    end else if (r_off == 6'd15) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_SRC;
                        w.fld_value = {32'd0, acc[31:0]};
                    end else if (r_off == 6'd19) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP4_DST;
                        w.fld_value = {32'd0, acc[31:0]};
                    end
                end
                phfe_pkg::LAYER_IP6: begin
                    if (r_off == 6'd6) n_proto = {8'd0, i_byte};
                    if (r_off == 6'd7) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP6_HOP;
                        w.fld_value = {56'd0, acc[7:0]};
                    end else if (r_off == 6'd15) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP6_SRC_H;
                        w.fld_value = acc;
                    end else if (r_off == 6'd23) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP6_SRC_L;
                        w.fld_value = acc;
                    end else if (r_off == 6'd31) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP6_DST_H;
                        w.fld_value = acc;
                    end else if (r_off == 6'd39) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_IP6_DST_L;
                        w.fld_value = acc;
                    end
                end
                phfe_pkg::LAYER_TCP: begin
                    if (r_off == 6'd12) n_hlen = tcp_len;
                    if (r_off == 6'd3) n_proto = acc[15:0];
                    if (r_off == 6'd1) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_TCP_SPORT;
                        w.fld_value = {48'd0, acc[15:0]};
                    end else if (r_off == 6'd3) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_TCP_DPORT;
                        w.fld_value = {48'd0, acc[15:0]};
                    end else if (r_off == 6'd7) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_TCP_SEQ;
                        w.fld_value = {32'd0, acc[31:0]};
                    end else if (r_off == 6'd11) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_TCP_ACK;
                        w.fld_value = {32'd0, acc[31:0]};
                    end else if (r_off == 6'd13) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_TCP_FLAGS;
                        w.fld_value = {55'd0, acc[8:0]};
                    end
                end
                phfe_pkg::LAYER_UDP: begin
                    if (r_off == 6'd3) n_proto = acc[15:0];
                    if (r_off == 6'd1) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_UDP_SPORT;
                        w.fld_value = {48'd0, acc[15:0]};
                    end else if (r_off == 6'd3) begin
                        w.fld_vld = 1'b1; w.fld_code = phfe_pkg::CODE_UDP_DPORT;
                        w.fld_value = {48'd0, acc[15:0]};
                    end
                end
                default: ;
            endcase
            // Header length compare uses the old length, as written before this byte.
            if ({1'b0, r_off} + 7'd1 >= {1'b0, r_hlen}) begin
                n_off = 6'd0;
                priority case (r_layer)
                    phfe_pkg::LAYER_ETH: begin
                        if (n_proto == 16'h0800) begin
                            n_layer = phfe_pkg::LAYER_IP4; n_hlen = 6'd20;
                        end else if (n_proto == 16'h86DD) begin
                            n_layer = phfe_pkg::LAYER_IP6; n_hlen = 6'd40;
                        end else begin
                            status_vld = 1'b1; status = phfe_pkg::STATUS_UNKNOWN;
                        end
                    end
                    phfe_pkg::LAYER_IP4, phfe_pkg::LAYER_IP6: begin
                        if (n_proto == 16'd6) begin
                            n_layer = phfe_pkg::LAYER_TCP; n_hlen = 6'd20;
                        end else if (n_proto == 16'd17) begin
                            n_layer = phfe_pkg::LAYER_UDP; n_hlen = 6'd8;
                        end else begin
                            status_vld = 1'b1; status = phfe_pkg::STATUS_UNKNOWN;
                        end
                    end
                    phfe_pkg::LAYER_TCP, phfe_pkg::LAYER_UDP: begin
                        status_vld = 1'b1; status = phfe_pkg::STATUS_COMPLETE;
                    end
                    default: begin
                        status_vld = 1'b1; status = phfe_pkg::STATUS_UNKNOWN;
                    end
                endcase
            end else begin
                n_off = r_off + 6'd1;
            end
            if (status_vld) n_done = 1'b1;
        end
        if (i_eop && !n_done) begin
            status_vld = 1'b1; status = phfe_pkg::STATUS_TRUNCATED;
        end
        w.end_vld = status_vld;
        w.end_status = status;
        if (i_eop) begin
            n_layer = phfe_pkg::LAYER_ETH; n_off = '0; n_hlen = 6'd14;
            n_acc = '0; n_proto = '0; n_done = 1'b0;
        end
    end

    assign o_work = w;
    assign o_work_vld = i_vld && (w.fld_vld || w.end_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= phfe_pkg::LAYER_ETH;
            r_off <= '0;
            r_hlen <= 6'd14;
            r_acc <= '0;
            r_proto <= '0;
            r_done <= 1'b0;
        end else if (i_vld) begin
            r_layer <= n_layer;
            r_off <= n_off;
            r_hlen <= n_hlen;
            r_acc <= n_acc;
            r_proto <= n_proto;
            r_done <= n_done;
        end
    end

    a_off_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> (r_off < r_hlen || r_off == 6'd0))
        else $error("byte offset beyond header length");
    a_eop_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && i_eop) |=> (r_off == 6'd0 && !r_done))
        else $error("frame end did not reset the parser");
    a_end_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_vld) |-> !w.fld_vld)
        else $error("field emitted after parse finished");

endmodule

// ===== sv/phfe_queue.sv =====
// Short queue of classified transactions between front and back end.
module phfe_queue #(
    parameter int Depth = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  phfe_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output phfe_pkg::t_work o_work,
    output logic            o_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    phfe_pkg::t_work r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full = (r_cnt == (AW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_work = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop) r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count out of range");

endmodule

// ===== sv/phfe_back.sv =====
// Back end: expands each queued entry into its field and end transactions.
module phfe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  phfe_pkg::t_work i_work,
    output logic            o_pop,
    output logic            o_vld,
    input  logic            i_rdy,
    output logic [4:0]      o_code,
    output logic [63:0]     o_value,
    output logic            o_last
);

    // Set once the field part of a two-result entry has been delivered.
    logic r_fld_sent;
    logic show_fld;

    assign show_fld = i_work.fld_vld && !r_fld_sent;
    assign o_vld = !i_empty;
    assign o_code = show_fld ? i_work.fld_code : phfe_pkg::CODE_END;
    assign o_value = show_fld ? i_work.fld_value : {62'd0, i_work.end_status};
    assign o_last = !show_fld;
    assign o_pop = o_vld && i_rdy && (!show_fld || !i_work.end_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld_sent <= 1'b0;
        end else if (o_pop) begin
            r_fld_sent <= 1'b0;
        end else if (o_vld && i_rdy && show_fld) begin
            r_fld_sent <= 1'b1;
        end
    end

    a_sent_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fld_sent |-> (!i_empty && i_work.end_vld))
        else $error("field marked sent without pending end");
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && o_last) |-> o_code == phfe_pkg::CODE_END)
        else $error("last without end code");
    a_end_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && i_rdy && show_fld && i_work.end_vld) |=> (o_vld && o_last))
        else $error("end result did not follow its field");

endmodule
